### hw/rtl/gpps_pkg.sv
// Shared types, codes and byte tables of the game pad poll sequencer.
package gpps_pkg;

    localparam logic [2:0] KIND_IDLE  = 3'd0;
    localparam logic [2:0] KIND_POLL  = 3'd1;
    localparam logic [2:0] KIND_ENTER = 3'd2;
    localparam logic [2:0] KIND_EXIT  = 3'd3;
    localparam logic [2:0] KIND_MODE  = 3'd4;
    localparam logic [2:0] KIND_MOTOR = 3'd5;
    localparam logic [2:0] KIND_INIT  = 3'd6;
    localparam logic [2:0] KIND_GAP   = 3'd7;

    localparam logic [3:0] INIT_LAST  = 4'd13;

    localparam logic [1:0] REG_SMALL_MOTOR = 2'd0;
    localparam logic [1:0] REG_LARGE_MOTOR = 2'd1;
    localparam logic [1:0] REG_CTRL_MODE   = 2'd2;

    localparam logic [7:0] BYTE_START   = 8'h01;
    localparam logic [7:0] BYTE_POLL    = 8'h42;
    localparam logic [7:0] BYTE_CONFIG  = 8'h43;
    localparam logic [7:0] BYTE_SETMODE = 8'h44;
    localparam logic [7:0] BYTE_MOTOR   = 8'h4D;
    localparam logic [7:0] BYTE_PAD     = 8'h5A;
    localparam logic [7:0] BYTE_LOCK    = 8'h03;
    localparam logic [7:0] BYTE_ONES    = 8'hFF;
    localparam logic [7:0] MODE_HI_MASK = 8'hF0;
    localparam logic [7:0] MODE_ANALOG  = 8'h70;

    typedef struct packed {
        logic [2:0] opcode;
        logic       data_bit;
    } t_in;

    typedef struct packed {
        logic        attention_level;
        logic        command_bit;
        logic        busy_res;
        logic        frame_done;
        logic        sequence_done;
        logic [15:0] button_bits;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  pad_mode;
    } t_out;

    // Classified item as it travels from the front to the back.
    typedef struct packed {
        logic       start;
        logic       init;
        logic [2:0] kind;
        logic       din;
    } t_op;

    function automatic logic [7:0] tx_byte(input logic [2:0] kind, input logic [3:0] idx,
                                           input logic [7:0] small_m, input logic [7:0] large_m,
                                           input logic [7:0] ctrl_mode);
        logic [7:0] b;
        b = 8'h00;
        if (idx <= 4'd8) begin
            unique case (kind)
                KIND_POLL: begin
                    unique case (idx)
                        4'd0:    b = BYTE_START;
                        4'd1:    b = BYTE_POLL;
                        4'd3:    b = small_m;
                        4'd4:    b = large_m;
                        default: b = 8'h00;
                    endcase
                end
                KIND_ENTER: begin
                    unique case (idx)
                        4'd0:    b = BYTE_START;
                        4'd1:    b = BYTE_CONFIG;
                        4'd3:    b = BYTE_START;
                        default: b = 8'h00;
                    endcase
                end
                KIND_EXIT: begin
                    unique case (idx)
                        4'd0:    b = BYTE_START;
                        4'd1:    b = BYTE_CONFIG;
                        4'd2:    b = 8'h00;
                        4'd3:    b = 8'h00;
                        default: b = BYTE_PAD;
                    endcase
                end
                KIND_MODE: begin
                    unique case (idx)
                        4'd0:    b = BYTE_START;
                        4'd1:    b = BYTE_SETMODE;
                        4'd3:    b = ctrl_mode;
                        4'd4:    b = BYTE_LOCK;
                        default: b = 8'h00;
                    endcase
                end
                KIND_MOTOR: begin
                    unique case (idx)
                        4'd0:    b = BYTE_START;
                        4'd1:    b = BYTE_MOTOR;
                        4'd2:    b = 8'h00;
                        4'd3:    b = 8'h00;
                        4'd4:    b = BYTE_START;
                        default: b = BYTE_ONES;
                    endcase
                end
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

    // Length in bytes; a poll grows to nine bytes when the pad reports analog mode.
    function automatic logic [3:0] frame_length(input logic [2:0] kind, input logic [7:0] mode);
        logic [3:0] len;
        if (kind == KIND_ENTER) begin
            len = 4'd5;
        end else if (kind == KIND_POLL) begin
            len = ((mode & MODE_HI_MASK) == MODE_ANALOG) ? 4'd9 : 4'd5;
        end else begin
            len = 4'd9;
        end
        return len;
    endfunction

    function automatic logic [2:0] init_kind(input logic [3:0] step);
        logic [2:0] k;
        unique case (step)
            4'd1, 4'd2:             k = KIND_ENTER;
            4'd3, 4'd4:             k = KIND_MODE;
            4'd5:                   k = KIND_MOTOR;
            4'd6, 4'd7, 4'd8, 4'd9: k = KIND_EXIT;
            default:                k = KIND_POLL;
        endcase
        return k;
    endfunction

endpackage

### hw/rtl/gpps_front.sv
// Front end: decodes each incoming item into a start/tick operation.
module gpps_front (
    input  gpps_pkg::t_in  i_item,
    input  logic           i_valid,
    output logic           o_ready,
    output gpps_pkg::t_op  o_op,
    output logic           o_push,
    input  logic           i_q_ready
);
    logic is_cmd;

    assign is_cmd = (i_item.opcode != gpps_pkg::KIND_IDLE) &&
                    (i_item.opcode != gpps_pkg::KIND_GAP);

    always_comb begin
        o_op.start = is_cmd;
        o_op.init  = (i_item.opcode == gpps_pkg::KIND_INIT);
        o_op.kind  = (i_item.opcode == gpps_pkg::KIND_INIT) ? gpps_pkg::KIND_POLL
                                                             : i_item.opcode;
        o_op.din   = i_item.data_bit;
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid & i_q_ready;
endmodule

### hw/rtl/gpps_queue.sv
// Two-entry queue between the front and the back.
module gpps_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gpps_pkg::t_op i_op,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output gpps_pkg::t_op o_op
);
    gpps_pkg::t_op r_mem [2];
    logic          r_wr_ptr, r_rd_ptr;
    logic [1:0]    r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

### hw/rtl/gpps_back.sv
// Back end: frame sequencer, bit shifter, receive stores and result register.
module gpps_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  gpps_pkg::t_op  i_op,
    output logic           o_pop,
    input  logic [7:0]     i_small_motor,
    input  logic [7:0]     i_large_motor,
    input  logic [7:0]     i_ctrl_mode,
    output logic           o_valid,
    input  logic           i_ready,
    output gpps_pkg::t_out o_out
);
    logic [2:0]  r_bit_count, n_bit_count;
    logic [3:0]  r_byte_index, n_byte_index;
    logic [2:0]  r_frame_kind, n_frame_kind;
    logic [3:0]  r_seq_step, n_seq_step;
    logic        r_init_run, n_init_run;
    logic [7:0]  r_rx, n_rx;
    logic [15:0] r_buttons, n_buttons;
    logic [7:0]  r_stick [4];
    logic [7:0]  n_stick [4];
    logic [7:0]  r_mode, n_mode;
    logic        r_out_valid;
    gpps_pkg::t_out r_out, n_out;

    logic [7:0]  tx;
    logic [3:0]  step_inc;
    logic [4:0]  next_idx;
    logic        att, cmd, fdone, sdone;

    assign o_pop   = i_q_valid & (~r_out_valid | i_ready);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    assign tx       = gpps_pkg::tx_byte(r_frame_kind, r_byte_index, i_small_motor,
                                        i_large_motor, i_ctrl_mode);
    assign step_inc = r_seq_step + 4'd1;
    assign next_idx = {1'b0, r_byte_index} + 5'd1;

    always_comb begin
        n_bit_count  = r_bit_count;
        n_byte_index = r_byte_index;
        n_frame_kind = r_frame_kind;
        n_seq_step   = r_seq_step;
        n_init_run   = r_init_run;
        n_rx         = r_rx;
        n_buttons    = r_buttons;
        n_mode       = r_mode;
        for (int i = 0; i < 4; i++) begin
            n_stick[i] = r_stick[i];
        end
        att   = 1'b1;
        cmd   = 1'b0;
        fdone = 1'b0;
        sdone = 1'b0;

        if (r_frame_kind == gpps_pkg::KIND_IDLE) begin
            if (i_op.start) begin
                n_init_run   = i_op.init;
                n_seq_step   = 4'd0;
                n_frame_kind = i_op.kind;
                n_bit_count  = 3'd0;
                n_byte_index = 4'd0;
                n_rx         = 8'h00;
                att          = 1'b0;
            end
        end else if (r_frame_kind == gpps_pkg::KIND_GAP) begin
            // Advance the init sequence and arm its next frame.
            n_seq_step   = (step_inc > gpps_pkg::INIT_LAST) ? gpps_pkg::INIT_LAST : step_inc;
            n_frame_kind = gpps_pkg::init_kind(n_seq_step);
            n_bit_count  = 3'd0;
            n_byte_index = 4'd0;
            n_rx         = 8'h00;
        end else begin
            att = 1'b0;
            cmd = tx[r_bit_count];
            if (r_bit_count == 3'd0) begin
                n_rx = {7'd0, i_op.din};
            end else begin
                n_rx = r_rx | ({7'd0, i_op.din} << r_bit_count);
            end
            if (r_bit_count == 3'd7) begin
                if (r_frame_kind == gpps_pkg::KIND_POLL) begin
                    if (r_byte_index == 4'd1) begin
                        n_mode = n_rx;
                    end else if (r_byte_index == 4'd3) begin
                        n_buttons = {8'h00, ~n_rx};
                    end else if (r_byte_index == 4'd4) begin
                        n_buttons = {~n_rx, r_buttons[7:0]};
                    end else if (r_byte_index >= 4'd5 && r_byte_index <= 4'd8) begin
                        for (int i = 0; i < 4; i++) begin
                            if (r_byte_index == 4'(i + 5)) begin
                                n_stick[i] = n_rx;
                            end
                        end
                    end
                end
                n_bit_count = 3'd0;
                if (next_idx >= {1'b0, gpps_pkg::frame_length(r_frame_kind, n_mode)}) begin
                    fdone        = 1'b1;
                    n_byte_index = 4'd0;
                    if (r_init_run && (r_seq_step < gpps_pkg::INIT_LAST)) begin
                        n_frame_kind = gpps_pkg::KIND_GAP;
                    end else begin
                        n_frame_kind = gpps_pkg::KIND_IDLE;
                        n_init_run   = 1'b0;
                        n_seq_step   = 4'd0;
                        sdone        = 1'b1;
                    end
                end else begin
                    n_byte_index = next_idx[3:0];
                end
            end else begin
                n_bit_count = r_bit_count + 3'd1;
            end
        end

        n_out.attention_level = att;
        n_out.command_bit     = cmd;
        n_out.busy_res        = (n_frame_kind != gpps_pkg::KIND_IDLE);
        n_out.frame_done      = fdone;
        n_out.sequence_done   = sdone;
        n_out.button_bits     = n_buttons;
        n_out.right_x         = n_stick[0];
        n_out.right_y         = n_stick[1];
        n_out.left_x          = n_stick[2];
        n_out.left_y          = n_stick[3];
        n_out.pad_mode        = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count  <= 3'd0;
            r_byte_index <= 4'd0;
            r_frame_kind <= gpps_pkg::KIND_IDLE;
            r_seq_step   <= 4'd0;
            r_init_run   <= 1'b0;
            r_rx         <= 8'h00;
            r_buttons    <= 16'h0000;
            r_mode       <= 8'h00;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_stick[i] <= 8'h00;
            end
        end else begin
            if (o_pop) begin
                r_bit_count  <= n_bit_count;
                r_byte_index <= n_byte_index;
                r_frame_kind <= n_frame_kind;
                r_seq_step   <= n_seq_step;
                r_init_run   <= n_init_run;
                r_rx         <= n_rx;
                r_buttons    <= n_buttons;
                r_mode       <= n_mode;
                for (int i = 0; i < 4; i++) begin
                    r_stick[i] <= n_stick[i];
                end
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end
endmodule

### hw/rtl/game_pad_poll_sequencer_core.sv
// Top level of the game pad poll sequencer: register port, front, queue and back.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | sink      | i_in_valid/o_in_ready  | i_in  (opcode, data_bit)
//  out     | source    | o_out_valid/i_out_ready| o_out (line levels, status, pad data)
//  config  | APB slave | psel/penable/pready    | paddr, pwdata, prdata
//
// One item per clock unless the output stalls: each accepted beat is decoded in the
// front, passes a two-entry queue and is executed by the back into the output register.
// A beat is registered in its queue entry and then in the output register.
// Reset (synchronous, active low) clears the queue, the sequencer, the pad stores
// and the motor/mode registers.
// A stalled output holds the back; the queue keeps accepting until it fills.
module game_pad_poll_sequencer_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gpps_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output gpps_pkg::t_out o_out,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    logic [7:0]    r_small_motor, r_large_motor, r_ctrl_mode;
    logic          cfg_wr;
    logic [1:0]    cfg_idx;
    gpps_pkg::t_op front_op, q_op;
    logic          push, pop, q_ready, q_valid;

    // Register port: always ready, write on the access phase.
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_motor <= 8'h00;
            r_large_motor <= 8'h00;
            r_ctrl_mode   <= 8'h00;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                gpps_pkg::REG_SMALL_MOTOR: r_small_motor <= pwdata[7:0];
                gpps_pkg::REG_LARGE_MOTOR: r_large_motor <= pwdata[7:0];
                gpps_pkg::REG_CTRL_MODE:   r_ctrl_mode   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            gpps_pkg::REG_SMALL_MOTOR: prdata = {24'd0, r_small_motor};
            gpps_pkg::REG_LARGE_MOTOR: prdata = {24'd0, r_large_motor};
            gpps_pkg::REG_CTRL_MODE:   prdata = {24'd0, r_ctrl_mode};
            default:                   prdata = 32'd0;
        endcase
    end

    // Decode the incoming beat.
    gpps_front u_front (
        .i_item    (i_in),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .o_op      (front_op),
        .o_push    (push),
        .i_q_ready (q_ready)
    );

    // Decouple the decoder from the sequencer.
    gpps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    // Run frames bit by bit and register one result per beat.
    gpps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_op          (q_op),
        .o_pop         (pop),
        .i_small_motor (r_small_motor),
        .i_large_motor (r_large_motor),
        .i_ctrl_mode   (r_ctrl_mode),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_out         (o_out)
    );
endmodule
